// ----- hw/rtl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the source token scanner
// token kinds, character classes and the scan step result record
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned SrcLen = 65536;
  localparam int unsigned PosW = 17;
  localparam int unsigned MaxNest = 255;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_BAD = 6'd1;
  localparam logic [5:0] K_UNTERM = 6'd2;
  localparam logic [5:0] K_PLUS = 6'd3;
  localparam logic [5:0] K_MINUS = 6'd4;
  localparam logic [5:0] K_STAR = 6'd5;
  localparam logic [5:0] K_SLASH = 6'd6;
  localparam logic [5:0] K_LPAREN = 6'd7;
  localparam logic [5:0] K_RPAREN = 6'd8;
  localparam logic [5:0] K_LBRACE = 6'd9;
  localparam logic [5:0] K_RBRACE = 6'd10;
  localparam logic [5:0] K_SEMI = 6'd11;
  localparam logic [5:0] K_COLON = 6'd12;
  localparam logic [5:0] K_DOT = 6'd13;
  localparam logic [5:0] K_DOTDOT = 6'd14;
  localparam logic [5:0] K_EQ = 6'd15;
  localparam logic [5:0] K_NOT = 6'd17;
  localparam logic [5:0] K_LT = 6'd19;
  localparam logic [5:0] K_GT = 6'd21;
  localparam logic [5:0] K_STRING = 6'd23;
  localparam logic [5:0] K_INT = 6'd24;
  localparam logic [5:0] K_FLOAT = 6'd25;
  localparam logic [5:0] K_IDENT = 6'd26;
  localparam logic [5:0] K_KW0 = 6'd27;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR,
    M_STRING, M_INT, M_INT_DOT, M_FLOAT, M_IDENT, M_OP2
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } burst_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic [15:0] cap16(input logic [PosW-1:0] v);
    return v[PosW-1] ? 16'hffff : v[15:0];
  endfunction

  // keyword table, bytes packed little end first
  function automatic logic [5:0] kw_match(input logic [55:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if (w[15:0] == 16'h6669) k = K_KW0 + 6'd3;
        if (w[15:0] == 16'h6e69) k = K_KW0 + 6'd6;
        if (w[15:0] == 16'h6e66) k = K_KW0 + 6'd8;
      end
      3'd3: begin
        if (w[23:0] == 24'h746e69) k = K_KW0;
        if (w[23:0] == 24'h726f66) k = K_KW0 + 6'd5;
      end
      3'd4: begin
        if (w[31:0] == 32'h6c6f6f62) k = K_KW0 + 6'd2;
        if (w[31:0] == 32'h65736c65) k = K_KW0 + 6'd4;
        if (w[31:0] == 32'h70657473) k = K_KW0 + 6'd7;
        if (w[31:0] == 32'h65757274) k = K_KW0 + 6'd10;
      end
      3'd5: begin
        if (w[39:0] == 40'h74616f6c66) k = K_KW0 + 6'd1;
        if (w[39:0] == 40'h65736c6166) k = K_KW0 + 6'd11;
      end
      3'd6: begin
        if (w[47:0] == 48'h6e7275746572) k = K_KW0 + 6'd9;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sts_core.sv -----
// ----------------------------------------------------------------------------
// sts_core: scanner state and single step logic
// consumes one registered character and produces up to three tokens
// ----------------------------------------------------------------------------
module sts_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_i,
  input  logic            end_i,
  output sts_pkg::burst_t burst_o
);
  import sts_pkg::*;

  mode_e            mode_q, mode_d;
  logic [7:0]       pend_q, pend_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  tstart_q, tstart_d;
  logic [15:0]      line_q, line_d;
  logic [7:0]       depth_q, depth_d;
  logic [55:0]      word_q, word_d;
  logic [2:0]       wlen_q, wlen_d;
  burst_t           b;

  function automatic logic [5:0] single_op(input logic [7:0] p);
    case (p)
      8'h2e:   return K_DOT;
      8'h3d:   return K_EQ;
      8'h21:   return K_NOT;
      8'h3c:   return K_LT;
      default: return K_GT;
    endcase
  endfunction

  function automatic logic [PosW-1:0] span(input logic [PosW-1:0] f, input logic [PosW-1:0] t);
    return t > f ? t - f : '0;
  endfunction

  always_comb begin
    logic [7:0]      c;
    logic [PosW-1:0] p, d;
    logic            restart, oc;
    logic [7:0]      op;
    b = '0;
    mode_d = mode_q; pend_d = pend_q; pos_d = pos_q; tstart_d = tstart_q;
    line_d = line_q; depth_d = depth_q; word_d = word_q; wlen_d = wlen_q;
    c = char_i; p = pos_q; restart = 1'b0; oc = 1'b0; op = pend_q;
    d = (p != '0) ? p - 1'b1 : '0;
    if (d < tstart_q) d = tstart_q;
    // push the pending tokens and the end token, line is taken at emission time
    if (end_i) begin
      unique case (mode_q)
        M_SLASH:   begin b.t0 = '{K_SLASH, cap16(tstart_q), 16'd1, line_q}; b.count = 2'd1; end
        M_STRING:  begin b.t0 = '{K_UNTERM, cap16(tstart_q), cap16(span(tstart_q, p)), line_q}; b.count = 2'd1; end
        M_INT:     begin b.t0 = '{K_INT, cap16(tstart_q), cap16(span(tstart_q, p)), line_q}; b.count = 2'd1; end
        M_INT_DOT: begin
          b.t0 = '{K_INT, cap16(tstart_q), cap16(span(tstart_q, d)), line_q};
          b.t1 = '{K_DOT, cap16(d), 16'd1, line_q}; b.count = 2'd2;
        end
        M_FLOAT:   begin b.t0 = '{K_FLOAT, cap16(tstart_q), cap16(span(tstart_q, p)), line_q}; b.count = 2'd1; end
        M_IDENT:   begin
          b.t0 = '{(span(tstart_q, p) == PosW'(wlen_q)) ? kw_match(word_q, wlen_q) : K_IDENT,
                   cap16(tstart_q), cap16(span(tstart_q, p)), line_q};
          b.count = 2'd1;
        end
        M_OP2:     begin b.t0 = '{single_op(pend_q), cap16(tstart_q), 16'd1, line_q}; b.count = 2'd1; end
        default:   b.count = 2'd0;
      endcase
      case (b.count)
        2'd0:    b.t0 = '{K_EOF, cap16(p), 16'd0, line_q};
        2'd1:    b.t1 = '{K_EOF, cap16(p), 16'd0, line_q};
        default: b.t2 = '{K_EOF, cap16(p), 16'd0, line_q};
      endcase
      b.count = b.count + 2'd1;
      mode_d = M_IDLE; pend_d = '0; pos_d = '0; tstart_d = '0; line_d = 16'd1;
      depth_d = '0; word_d = '0; wlen_d = '0;
    end else begin
      if (pos_q < PosW'(SrcLen)) pos_d = pos_q + 1'b1;
      unique case (mode_q)
        M_SLASH: begin
          if (c == 8'h2f) mode_d = M_LINE;
          else if (c == 8'h2a) begin mode_d = M_BLOCK; depth_d = 8'd1; end
          else begin
            b.t0 = '{K_SLASH, cap16(tstart_q), 16'd1, line_q}; b.count = 2'd1; restart = 1'b1;
          end
        end
        M_LINE: if (c == 8'h0a) begin
          mode_d = M_IDLE;
          if (line_q != 16'hffff) line_d = line_q + 1'b1;
        end
        M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR: begin
          if (mode_q == M_BLOCK_SLASH && c == 8'h2a) begin
            if (depth_q < 8'(MaxNest)) depth_d = depth_q + 1'b1;
            mode_d = M_BLOCK;
          end else if (mode_q == M_BLOCK_STAR && c == 8'h2f) begin
            depth_d = (depth_q != '0) ? depth_q - 1'b1 : '0;
            mode_d = (depth_d == '0) ? M_IDLE : M_BLOCK;
          end else begin
            mode_d = M_BLOCK;
            if (c == 8'h2f) mode_d = M_BLOCK_SLASH;
            else if (c == 8'h2a) mode_d = M_BLOCK_STAR;
            else if (c == 8'h0a && line_q != 16'hffff) line_d = line_q + 1'b1;
          end
        end
        M_STRING: if (c == 8'h22) begin
          b.t0 = '{K_STRING, cap16(tstart_q + 1'b1), cap16(span(tstart_q + 1'b1, p)), line_q};
          b.count = 2'd1; mode_d = M_IDLE;
        end
        M_INT: begin
          if (c == 8'h2e) mode_d = M_INT_DOT;
          else if (!is_digit(c)) begin
            b.t0 = '{K_INT, cap16(tstart_q), cap16(span(tstart_q, p)), line_q};
            b.count = 2'd1; restart = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(c)) mode_d = M_FLOAT;
          else begin
            b.t0 = '{K_INT, cap16(tstart_q), cap16(span(tstart_q, d)), line_q};
            b.count = 2'd1; tstart_d = d; op = 8'h2e; oc = 1'b1;
          end
        end
        M_FLOAT: if (!is_digit(c)) begin
          b.t0 = '{K_FLOAT, cap16(tstart_q), cap16(span(tstart_q, p)), line_q};
          b.count = 2'd1; restart = 1'b1;
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (wlen_q < 3'd7) begin
              word_d = word_q | (56'(c) << {wlen_q, 3'b000});
              wlen_d = wlen_q + 1'b1;
            end
          end else begin
            b.t0 = '{(span(tstart_q, p) == PosW'(wlen_q)) ? kw_match(word_q, wlen_q) : K_IDENT,
                     cap16(tstart_q), cap16(span(tstart_q, p)), line_q};
            b.count = 2'd1; restart = 1'b1;
          end
        end
        M_OP2:   oc = 1'b1;
        default: restart = 1'b1;
      endcase
      // two-character operator resolution
      if (oc) begin
        mode_d = M_IDLE;
        if (c == 8'h3d && op != 8'h2e) begin
          b.count = b.count + 2'd1;
          if (b.count == 2'd1) b.t0 = '{single_op(op) + 6'd1, cap16(tstart_d), 16'd2, line_q};
          else b.t1 = '{single_op(op) + 6'd1, cap16(tstart_d), 16'd2, line_q};
        end else if (c == 8'h2e && op == 8'h2e) begin
          b.count = b.count + 2'd1;
          if (b.count == 2'd1) b.t0 = '{K_DOTDOT, cap16(tstart_d), 16'd2, line_q};
          else b.t1 = '{K_DOTDOT, cap16(tstart_d), 16'd2, line_q};
        end else begin
          b.count = b.count + 2'd1;
          if (b.count == 2'd1) b.t0 = '{single_op(op), cap16(tstart_d), 16'd1, line_q};
          else b.t1 = '{single_op(op), cap16(tstart_d), 16'd1, line_q};
          restart = 1'b1;
        end
      end
      // start of a new token on this character
      if (restart) begin
        logic [5:0] k;
        logic       em;
        k = K_BAD; em = 1'b0;
        mode_d = M_IDLE; tstart_d = p;
        case (c)
          8'h20, 8'h09, 8'h0d: em = 1'b0;
          8'h0a: if (line_q != 16'hffff) line_d = line_q + 1'b1;
          8'h2b: begin k = K_PLUS; em = 1'b1; end
          8'h2d: begin k = K_MINUS; em = 1'b1; end
          8'h2a: begin k = K_STAR; em = 1'b1; end
          8'h28: begin k = K_LPAREN; em = 1'b1; end
          8'h29: begin k = K_RPAREN; em = 1'b1; end
          8'h7b: begin k = K_LBRACE; em = 1'b1; end
          8'h7d: begin k = K_RBRACE; em = 1'b1; end
          8'h3b: begin k = K_SEMI; em = 1'b1; end
          8'h3a: begin k = K_COLON; em = 1'b1; end
          8'h2f: mode_d = M_SLASH;
          8'h2e, 8'h3d, 8'h21, 8'h3c, 8'h3e: begin pend_d = c; mode_d = M_OP2; end
          8'h22: mode_d = M_STRING;
          default: begin
            if (is_digit(c)) mode_d = M_INT;
            else if (is_alpha(c)) begin
              mode_d = M_IDENT; word_d = 56'(c); wlen_d = 3'd1;
            end else em = 1'b1;
          end
        endcase
        if (em) begin
          b.count = b.count + 2'd1;
          case (b.count)
            2'd1:    b.t0 = '{k, cap16(p), 16'd1, line_q};
            2'd2:    b.t1 = '{k, cap16(p), 16'd1, line_q};
            default: b.t2 = '{k, cap16(p), 16'd1, line_q};
          endcase
        end
      end
    end
  end

  assign burst_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= '0; pos_q <= '0; tstart_q <= '0;
      line_q <= 16'd1; depth_q <= '0; word_q <= '0; wlen_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; pend_q <= pend_d; pos_q <= pos_d; tstart_q <= tstart_d;
      line_q <= line_d; depth_q <= depth_d; word_q <= word_d; wlen_q <= wlen_d;
    end
  end
endmodule

// ----- hw/rtl/source_token_scanner.sv -----
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexical scanner
// bytes in, tokens out as kind, offset, length and line
// path: a byte waits in the input register, then its tokens in the token burst register
// throughput: one byte per cycle unless out_stall_i; extra tokens of a byte hold the next byte
// the token burst register drains one token a cycle unless stalled and sets the pace
// reset: asynchronous, line one, offset zero, no tokens pending
// ----------------------------------------------------------------------------
module source_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] lexeme_start_o,
  output logic [15:0] lexeme_length_o,
  output logic [15:0] line_number_o,
  output logic        last_of_run_o
);
  import sts_pkg::*;

  // input register
  logic       iv_q;
  logic [7:0] ic_q;
  logic       ie_q;
  // token burst register, drained one token a cycle unless stalled
  burst_t     bst_q;
  logic [1:0] idx_q;
  logic       bv_q;
  burst_t     bst;
  logic       take, last, step, free;
  tok_t       cur;

  sts_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (ic_q),
    .end_i  (ie_q),
    .burst_o(bst)
  );

  always_comb begin
    case (idx_q)
      2'd0:    cur = bst_q.t0;
      2'd1:    cur = bst_q.t1;
      default: cur = bst_q.t2;
    endcase
  end

  assign last  = (idx_q + 2'd1) == bst_q.count;
  assign take  = bv_q && !out_stall_i;
  // burst register is free when empty or its final token leaves now
  assign free  = !bv_q || (take && last);
  assign step  = iv_q && free;
  assign in_stall_o = iv_q && !free;

  assign out_valid_o     = bv_q;
  assign token_kind_o    = cur.kind;
  assign lexeme_start_o  = cur.start;
  assign lexeme_length_o = cur.len;
  assign line_number_o   = cur.line;
  assign last_of_run_o   = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0; bv_q <= 1'b0; idx_q <= '0;
    end else begin
      if (!in_stall_o) iv_q <= in_valid_i;
      if (step) begin
        bv_q  <= bst.count != 2'd0;
        idx_q <= '0;
      end else if (take) begin
        if (last) bv_q <= 1'b0;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      ic_q <= char_byte_i;
      ie_q <= end_of_source_i;
    end
    if (step) bst_q <= bst;
  end
endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: source token scanner
// drives byte streams with end markers through the valid/stall channels and
// compares every emitted token against a behavioural scanner model kept here
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sts_pkg::*;

  // scanner modes kept by the predictor
  typedef enum logic [3:0] {
    S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BLK_SLASH, S_BLK_STAR,
    S_STRING, S_INT, S_INT_DOT, S_FLOAT, S_IDENT, S_OP2
  } scan_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_byte_i = '0;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [5:0]  token_kind_o;
  logic [15:0] lexeme_start_o;
  logic [15:0] lexeme_length_o;
  logic [15:0] line_number_o;
  logic        last_of_run_o;

  always #1 clk_i = ~clk_i;

  source_token_scanner i_dut (.*);

  // predictor state
  scan_e       mode_q;
  logic [7:0]  pend_q;
  int unsigned pos_q, tstart_q, line_q, depth_q, wlen_q;
  logic [55:0] word_q;
  token_t      burst[$];
  token_t      expected_tokens[$];
  int          n_errors = 0;
  int          n_tokens = 0;
  int          n_bytes = 0;
  int          n_sources = 0;
  logic        stall_ready = 1'b0;

  function automatic logic [15:0] sat16(int unsigned v);
    return v > 65535 ? 16'hffff : v[15:0];
  endfunction

  function automatic logic digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return b > a ? b - a : 0;
  endfunction

  task automatic push_tok(logic [5:0] k, int unsigned s, int unsigned l);
    token_t t;
    if (burst.size() >= 3) return;
    t.kind = k; t.start = sat16(s); t.len = sat16(l); t.line = sat16(line_q); t.last = 0;
    burst.push_back(t);
  endtask

  task automatic bump_line();
    if (line_q < 65535) line_q++;
  endtask

  function automatic logic [5:0] single_kind(logic [7:0] p);
    case (p)
      ".": return K_DOT;
      "=": return K_EQ;
      "!": return K_NOT;
      "<": return K_LT;
      default: return K_GT;
    endcase
  endfunction

  // identifier or keyword, matched on the stored prefix
  task automatic push_word(int unsigned pos);
    int unsigned n;
    logic [5:0]  k;
    n = gap(tstart_q, pos);
    k = K_IDENT;
    if (n == wlen_q) begin
      case (n)
        2: case (word_q[15:0])
          "fi": k = K_KW0 + 3;
          "ni": k = K_KW0 + 6;
          "nf": k = K_KW0 + 8;
          default: ;
        endcase
        3: case (word_q[23:0])
          "tni": k = K_KW0;
          "rof": k = K_KW0 + 5;
          default: ;
        endcase
        4: case (word_q[31:0])
          "loob": k = K_KW0 + 2;
          "esle": k = K_KW0 + 4;
          "pets": k = K_KW0 + 7;
          "eurt": k = K_KW0 + 10;
          default: ;
        endcase
        5: case (word_q[39:0])
          "taolf": k = K_KW0 + 1;
          "eslaf": k = K_KW0 + 11;
          default: ;
        endcase
        6: if (word_q[47:0] == "nruter") k = K_KW0 + 9;
        default: ;
      endcase
    end
    push_tok(k, tstart_q, n);
  endtask

  task automatic begin_token(logic [7:0] c, int unsigned pos);
    mode_q = S_IDLE;
    tstart_q = pos;
    case (c)
      " ", 8'h09, 8'h0d: ;
      8'h0a: bump_line();
      "+": push_tok(K_PLUS, pos, 1);
      "-": push_tok(K_MINUS, pos, 1);
      "*": push_tok(K_STAR, pos, 1);
      "(": push_tok(K_LPAREN, pos, 1);
      ")": push_tok(K_RPAREN, pos, 1);
      "{": push_tok(K_LBRACE, pos, 1);
      "}": push_tok(K_RBRACE, pos, 1);
      ";": push_tok(K_SEMI, pos, 1);
      ":": push_tok(K_COLON, pos, 1);
      "/": mode_q = S_SLASH;
      ".", "=", "!", "<", ">": begin
        pend_q = c;
        mode_q = S_OP2;
      end
      8'h22: mode_q = S_STRING;
      default: begin
        if (digit_c(c)) mode_q = S_INT;
        else if (alpha_c(c)) begin
          mode_q = S_IDENT;
          word_q = {48'd0, c};
          wlen_q = 1;
        end else push_tok(K_BAD, pos, 1);
      end
    endcase
  endtask

  task automatic in_block(logic [7:0] c);
    mode_q = S_BLOCK;
    if (c == "/") mode_q = S_BLK_SLASH;
    else if (c == "*") mode_q = S_BLK_STAR;
    else if (c == 8'h0a) bump_line();
  endtask

  task automatic second_op(logic [7:0] c, int unsigned pos);
    mode_q = S_IDLE;
    if (c == "=" && pend_q != ".") push_tok(single_kind(pend_q) + 6'd1, tstart_q, 2);
    else if (c == "." && pend_q == ".") push_tok(K_DOTDOT, tstart_q, 2);
    else begin
      push_tok(single_kind(pend_q), tstart_q, 1);
      begin_token(c, pos);
    end
  endtask

  function automatic int unsigned dot_at(int unsigned pos);
    int unsigned d;
    d = pos ? pos - 1 : 0;
    return d < tstart_q ? tstart_q : d;
  endfunction

  task automatic reset_scanner();
    mode_q = S_IDLE; pend_q = 0; pos_q = 0; tstart_q = 0; line_q = 1;
    depth_q = 0; word_q = 0; wlen_q = 0;
  endtask

  // one input transaction through the predictor; queues its tokens
  task automatic predict_tokens(logic [7:0] c, logic eos);
    int unsigned d;
    burst.delete();
    if (eos) begin
      case (mode_q)
        S_SLASH: push_tok(K_SLASH, tstart_q, 1);
        S_STRING: push_tok(K_UNTERM, tstart_q, gap(tstart_q, pos_q));
        S_INT: push_tok(K_INT, tstart_q, gap(tstart_q, pos_q));
        S_INT_DOT: begin
          d = dot_at(pos_q);
          push_tok(K_INT, tstart_q, gap(tstart_q, d));
          push_tok(K_DOT, d, 1);
        end
        S_FLOAT: push_tok(K_FLOAT, tstart_q, gap(tstart_q, pos_q));
        S_IDENT: push_word(pos_q);
        S_OP2: push_tok(single_kind(pend_q), tstart_q, 1);
        default: ;
      endcase
      push_tok(K_EOF, pos_q, 0);
      reset_scanner();
    end else begin
      case (mode_q)
        S_SLASH:
          if (c == "/") mode_q = S_LINE;
          else if (c == "*") begin
            mode_q = S_BLOCK;
            depth_q = 1;
          end else begin
            push_tok(K_SLASH, tstart_q, 1);
            begin_token(c, pos_q);
          end
        S_LINE: if (c == 8'h0a) begin
          bump_line();
          mode_q = S_IDLE;
        end
        S_BLOCK: in_block(c);
        S_BLK_SLASH:
          if (c == "*") begin
            if (depth_q < MaxNest) depth_q++;
            mode_q = S_BLOCK;
          end else in_block(c);
        S_BLK_STAR:
          if (c == "/") begin
            if (depth_q > 0) depth_q--;
            mode_q = depth_q == 0 ? S_IDLE : S_BLOCK;
          end else in_block(c);
        S_STRING: if (c == 8'h22) begin
          push_tok(K_STRING, tstart_q + 1, gap(tstart_q + 1, pos_q));
          mode_q = S_IDLE;
        end
        S_INT:
          if (c == ".") mode_q = S_INT_DOT;
          else if (!digit_c(c)) begin
            push_tok(K_INT, tstart_q, gap(tstart_q, pos_q));
            begin_token(c, pos_q);
          end
        S_INT_DOT:
          if (digit_c(c)) mode_q = S_FLOAT;
          else begin
            d = dot_at(pos_q);
            push_tok(K_INT, tstart_q, gap(tstart_q, d));
            tstart_q = d;
            pend_q = ".";
            second_op(c, pos_q);
          end
        S_FLOAT: if (!digit_c(c)) begin
          push_tok(K_FLOAT, tstart_q, gap(tstart_q, pos_q));
          begin_token(c, pos_q);
        end
        S_IDENT:
          if (alpha_c(c) || digit_c(c)) begin
            if (wlen_q < 7) begin
              word_q[8*wlen_q +: 8] = c;
              wlen_q++;
            end
          end else begin
            push_word(pos_q);
            begin_token(c, pos_q);
          end
        S_OP2: second_op(c, pos_q);
        default: begin_token(c, pos_q);
      endcase
      if (pos_q < SrcLen) pos_q++;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_tokens.push_back(burst[i]);
  endtask

  // send one byte or end marker, with a random gap in front
  task automatic send_byte(logic [7:0] c, logic eos);
    int unsigned idle;
    idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 1)) idle = 0;
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_byte_i <= c;
    end_of_source_i <= eos;
    // stall is stable from the falling edge to the next rising edge
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_tokens(c, eos);
    if (eos) n_sources++;
    else n_bytes++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_byte(8'h00, 1'b1);
  endtask

  // every operator, keyword and literal form, and the special cases
  task automatic test_tokens();
    send_text("+-*/(){};:. .. = == ! != < <= > >= /");
    end_source();
    send_text("int float bool if else for in step fn return true false ");
    send_text("iff _Zq9 abcdefghij \"s\n\" 12.x 3.. 4.5 7.=");
    end_source();
    send_text("12.");
    end_source();
    send_text("a\n//c\n/* x /* y */ z */b\n\"open");
    end_source();
    send_text("/* never closed");
    end_source();
    end_source();
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_text("@#$");
    end_source();
  endtask

  function automatic string rand_piece();
    static string parts[] = '{"int", "float", "bool", "if", "else", "for", "in",
      "step", "fn", "return", "true", "false", "x1", "_ab", "42", "3.14", "7.",
      "..", "==", "!=", "<=", ">=", "=", "<", ">", "!", "+", "-", "*", "/",
      "(", ")", "{", "}", ";", ":", ".", " ", "\n", "\t", "\"str\"",
      "// note\n", "/* c /* d */ */", "returned", "\r"};
    return parts[$urandom_range(0, parts.size() - 1)];
  endfunction

  // well formed token soup, with some raw random bytes mixed in
  task automatic test_random();
    int sent;
    string s;
    sent = 0;
    while (sent < 110) begin
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        sent++;
      end else begin
        s = rand_piece();
        send_text(s);
        sent += s.len();
      end
      if ($urandom_range(0, 40) == 0) begin
        end_source();
        sent++;
      end
    end
    end_source();
  endtask

  // nested block comments with newlines inside, then newline counting
  task automatic test_nesting();
    repeat (3) send_text("/*");
    send_text("a\n");
    repeat (3) send_text("*/");
    send_text("\n\nq");
    end_source();
  endtask

  // receiver: random stall per transaction, checks the oldest expectation
  initial begin
    int unsigned hold;
    token_t exp_t;
    token_t got;
    wait (stall_ready);
    forever begin
      hold = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      got.kind = token_kind_o;
      got.start = lexeme_start_o;
      got.len = lexeme_length_o;
      got.line = line_number_o;
      got.last = last_of_run_o;
      @(posedge clk_i);
      n_tokens++;
      if (expected_tokens.size() == 0) begin
        $error("token with no expectation: kind %0d", got.kind);
        n_errors++;
      end else begin
        exp_t = expected_tokens.pop_front();
        if (got.kind !== exp_t.kind) begin
          $error("token_kind expected %0d actual %0d", exp_t.kind, got.kind);
          n_errors++;
        end
        if (got.start !== exp_t.start) begin
          $error("lexeme_start expected %0d actual %0d", exp_t.start, got.start);
          n_errors++;
        end
        if (got.len !== exp_t.len) begin
          $error("lexeme_length expected %0d actual %0d", exp_t.len, got.len);
          n_errors++;
        end
        if (got.line !== exp_t.line) begin
          $error("line_number expected %0d actual %0d", exp_t.line, got.line);
          n_errors++;
        end
        if (got.last !== exp_t.last) begin
          $error("last_of_run expected %0d actual %0d", exp_t.last, got.last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    reset_scanner();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_ready = 1'b1;
    test_tokens();
    test_nesting();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d source bytes in %0d sources, %0d tokens checked",
             n_bytes, n_sources, n_tokens);
    if (n_errors == 0 && expected_tokens.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sts_pkg.sv
hw/rtl/sts_core.sv
hw/rtl/source_token_scanner.sv
tb/sv/testbench.sv
